// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the ring buffer rtl
// no dependencies; the assertion bodies drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/vlmrb_pkg.sv =====
// shared types and constants for the variable-length message ring buffer
// no dependencies; imported by the interfaces, controller, datapath and top level of the block
`default_nettype none

package vlmrb_pkg;

	localparam int OP_W = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 12;
	localparam int STATUS_W = 3;
	localparam int HI_W = LEN_W - BYTE_W;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int HEADER_BYTES_DEF = 4;
	// free space must exceed the length plus this many headers
	localparam int HEADER_SLACK = 3;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

	// header byte 1: marker flag on top, length bits 11..8 below
	localparam int MARK_BIT = BYTE_W - 1;
	localparam logic [BYTE_W-1:0] HDR_MARK = 8'h80;
	localparam logic [BYTE_W-1:0] MARK_LEN = 8'h01;

	typedef enum logic [3:0] {
		A_WO     = 4'd0,
		A_WO1    = 4'd1,
		A_WO_H   = 4'd2,
		A_WPTR   = 4'd3,
		A_HPOS   = 4'd4,
		A_HPOS1  = 4'd5,
		A_HPOS_H = 4'd6,
		A_RDP    = 4'd7,
		A_ONE    = 4'd8
	} addr_sel_t;

	typedef enum logic [2:0] {
		D_MARK_LO = 3'd0,
		D_MARK_HI = 3'd1,
		D_LEN_LO  = 3'd2,
		D_LEN_HI  = 3'd3,
		D_BYTE    = 3'd4
	} wdata_sel_t;

	typedef struct packed {
		logic load;
		logic mem_we;
		logic mem_re;
		addr_sel_t addr;
		wdata_sel_t wsel;
		logic set_st;
		logic [STATUS_W-1:0] st;
		logic drop_step;
		logic wr_step;
		logic reject;
		logic wo_clear;
		logic wr_first;
		logic hdr_wrap;
		logic hdr_hi;
		logic hdr_done;
		logic rd_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic op_wr;
		logic op_rd;
		logic op_pk;
		logic send_busy;
		logic dropping;
		logic recv_busy;
		logic len_zero;
		logic empty;
		logic wrap;
		logic fit;
		logic marker;
		logic wrapped;
		logic wo_zero;
		logic hlen_zero;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vlmrb_in_if.sv =====
// request channel of the ring buffer: valid/ready plus one request item
// depends on vlmrb_pkg for the field widths
`default_nettype none

interface vlmrb_in_if import vlmrb_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0] msg_length;

	modport source (output valid, op, data_byte, msg_length, input ready);
	modport sink (input valid, op, data_byte, msg_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vlmrb_out_if.sv =====
// response channel of the ring buffer: valid/ready plus one result item
// depends on vlmrb_pkg for the field widths
`default_nettype none

interface vlmrb_out_if import vlmrb_pkg::*; ();
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] read_byte;
	logic last;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0] next_size;

	modport source (output valid, read_byte, last, status, next_size, input ready);
	modport sink (input valid, read_byte, last, status, next_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vlmrb_ram.sv =====
// single-port ram with registered read, generic in width and depth
// no dependencies
`default_nettype none

module vlmrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/vlmrb_ctrl.sv =====
// controller of the ring buffer: sequences store accesses and bookkeeping
// depends on vlmrb_pkg (cmd_t, sts_t, status codes) and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module vlmrb_ctrl
	import vlmrb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_EVAL  = 11'b000_0000_0010,
		S_MARK0 = 11'b000_0000_0100,
		S_MARK1 = 11'b000_0000_1000,
		S_HDR0  = 11'b000_0001_0000,
		S_HDR1  = 11'b000_0010_0000,
		S_WDATA = 11'b000_0100_0000,
		S_HCHK  = 11'b000_1000_0000,
		S_HLO   = 11'b001_0000_0000,
		S_RDATA = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic fit_q, fit_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		fit_d = fit_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_DONE;
				priority if (sts.op_wr) begin
					priority if (sts.send_busy && sts.dropping) begin
						cmd.drop_step = 1'b1;
						cmd.set_st = 1'b1;
						cmd.st = ST_DROPPED;
					end else if (sts.send_busy) begin
						cmd.mem_we = 1'b1;
						cmd.addr = A_WPTR;
						cmd.wsel = D_BYTE;
						cmd.wr_step = 1'b1;
					end else if (sts.len_zero) begin
						cmd.set_st = 1'b1;
						cmd.st = ST_ZERO;
					end else begin
						// rejection bookkeeping does not depend on the marker writes
						if (!sts.fit) begin
							cmd.reject = 1'b1;
							cmd.set_st = 1'b1;
							cmd.st = ST_NOSPACE;
						end
						fit_d = sts.fit;
						if (sts.wrap) begin
							state_d = S_MARK0;
						end else if (sts.fit) begin
							state_d = S_HDR0;
						end
					end
				end else if (sts.op_rd) begin
					priority if (sts.recv_busy) begin
						cmd.mem_re = 1'b1;
						cmd.addr = A_RDP;
						state_d = S_RDATA;
					end else if (sts.len_zero) begin
						cmd.set_st = 1'b1;
						cmd.st = ST_ZERO;
					end else if (sts.empty) begin
						cmd.set_st = 1'b1;
						cmd.st = ST_EMPTY;
					end else begin
						cmd.mem_re = 1'b1;
						cmd.addr = A_HPOS1;
						state_d = S_HCHK;
					end
				end else if (sts.op_pk) begin
					if (sts.empty) begin
						cmd.set_st = 1'b1;
						cmd.st = ST_EMPTY;
					end else begin
						cmd.mem_re = 1'b1;
						cmd.addr = A_HPOS1;
						state_d = S_HCHK;
					end
				end else begin
					// unused op: all-zero result
					state_d = S_DONE;
				end
			end
			S_MARK0: begin
				cmd.mem_we = 1'b1;
				cmd.addr = A_WO;
				cmd.wsel = D_MARK_LO;
				state_d = S_MARK1;
			end
			S_MARK1: begin
				cmd.mem_we = 1'b1;
				cmd.addr = A_WO1;
				cmd.wsel = D_MARK_HI;
				cmd.wo_clear = 1'b1;
				state_d = fit_q ? S_HDR0 : S_DONE;
			end
			S_HDR0: begin
				cmd.mem_we = 1'b1;
				cmd.addr = A_WO;
				cmd.wsel = D_LEN_LO;
				state_d = S_HDR1;
			end
			S_HDR1: begin
				cmd.mem_we = 1'b1;
				cmd.addr = A_WO1;
				cmd.wsel = D_LEN_HI;
				state_d = S_WDATA;
			end
			S_WDATA: begin
				cmd.mem_we = 1'b1;
				cmd.addr = A_WO_H;
				cmd.wsel = D_BYTE;
				cmd.wr_first = 1'b1;
				state_d = S_DONE;
			end
			S_HCHK: begin
				// store data is header byte 1 of the candidate message
				priority if (sts.marker && sts.wrapped) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_EMPTY;
					state_d = S_DONE;
				end else if (sts.marker && sts.wo_zero) begin
					cmd.hdr_wrap = 1'b1;
					cmd.set_st = 1'b1;
					cmd.st = ST_EMPTY;
					state_d = S_DONE;
				end else if (sts.marker) begin
					cmd.hdr_wrap = 1'b1;
					cmd.mem_re = 1'b1;
					cmd.addr = A_ONE;
					state_d = S_HCHK;
				end else begin
					cmd.hdr_hi = 1'b1;
					cmd.mem_re = 1'b1;
					cmd.addr = A_HPOS;
					state_d = S_HLO;
				end
			end
			S_HLO: begin
				priority if (sts.hlen_zero) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_EMPTY;
					state_d = S_DONE;
				end else if (sts.op_pk) begin
					cmd.hdr_done = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.hdr_done = 1'b1;
					cmd.mem_re = 1'b1;
					cmd.addr = A_HPOS_H;
					state_d = S_RDATA;
				end
			end
			S_RDATA: begin
				cmd.rd_step = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fit_q <= fit_d;
		end
	end

	`ASSERT_CLK(a_accept_to_eval, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_EVAL))
	`ASSERT_CLK(a_done_waits, clk, arst_n, (state_q == S_DONE && !sts.out_free) |=> (state_q == S_DONE))
	`ASSERT_NEVER(a_mem_rw_clash, clk, arst_n, cmd.mem_we && cmd.mem_re)

endmodule

`default_nettype wire

// ===== hw/rtl/vlmrb_dp.sv =====
// datapath of the ring buffer: offsets, counters, byte store and result registers
// depends on vlmrb_pkg, vlmrb_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module vlmrb_dp
	import vlmrb_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [OP_W-1:0]     in_op,
	input  logic [BYTE_W-1:0]   in_byte,
	input  logic [LEN_W-1:0]    in_len,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                out_last,
	output logic [STATUS_W-1:0] out_status,
	output logic [LEN_W-1:0]    out_size,
	input  cmd_t                cmd,
	output sts_t                sts
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int CW = (AW + 1 > LEN_W + 1) ? AW + 1 : LEN_W + 1;
	localparam logic [AW:0] STORE_W = (AW + 1)'(STORE_BYTES);
	localparam logic [AW-1:0] ONE_A = AW'(1);
	localparam logic [AW-1:0] HDR_A = AW'(HEADER_BYTES);
	localparam logic [AW-1:0] HDR1_A = AW'(HEADER_BYTES + 1);
	localparam logic [CW-1:0] SLACK_C = CW'(HEADER_SLACK * HEADER_BYTES);

	// offset plus step, folded back into the store
	function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= STORE_W) begin
			s = s - STORE_W;
		end
		return s[AW-1:0];
	endfunction

	logic [OP_W-1:0] op_q;
	logic [BYTE_W-1:0] byte_q;
	logic [LEN_W-1:0] len_q;
	logic [AW-1:0] wo_q, ro_q, wptr_q, rdp_q;
	logic [LEN_W-1:0] send_left_q, recv_left_q;
	logic dropping_q, hwrap_q;
	logic [HI_W-1:0] hi_q;
	logic [BYTE_W-1:0] res_byte_q;
	logic res_last_q;
	logic [STATUS_W-1:0] res_st_q;
	logic [LEN_W-1:0] res_size_q;
	logic out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic out_last_q;
	logic [STATUS_W-1:0] out_st_q;
	logic [LEN_W-1:0] out_size_q;

	logic [AW-1:0] hpos;
	logic [AW:0] free_w;
	logic [CW-1:0] need_w;
	logic fit0, fit1, wrap_w;
	logic [AW-1:0] mem_addr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;
	logic [LEN_W-1:0] hlen;
	logic op_rd, op_pk;

	assign op_rd = (op_q == OP_READ);
	assign op_pk = (op_q == OP_PEEK);
	assign hpos = hwrap_q ? '0 : ro_q;
	assign hlen = {hi_q, mem_rdata};

	// space up to the store end, or up to the read offset once wrapped
	assign free_w = (wo_q >= ro_q) ? (STORE_W - {1'b0, wo_q}) : ({1'b0, ro_q} - {1'b0, wo_q});
	assign need_w = CW'(len_q) + SLACK_C;
	assign fit0 = CW'(free_w) > need_w;
	assign wrap_w = !fit0 && (wo_q >= ro_q) && (ro_q != '0);
	assign fit1 = CW'(ro_q) > need_w;

	always_comb begin
		sts.op_wr = (op_q == OP_WRITE);
		sts.op_rd = op_rd;
		sts.op_pk = op_pk;
		sts.send_busy = (send_left_q != '0);
		sts.dropping = dropping_q;
		sts.recv_busy = (recv_left_q != '0);
		sts.len_zero = (len_q == '0);
		sts.empty = (ro_q == wo_q);
		sts.wrap = wrap_w;
		sts.fit = fit0 || (wrap_w && fit1);
		sts.marker = mem_rdata[MARK_BIT];
		sts.wrapped = hwrap_q;
		sts.wo_zero = (wo_q == '0);
		sts.hlen_zero = (hlen == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		unique case (cmd.addr)
			A_WO:     mem_addr = wo_q;
			A_WO1:    mem_addr = add_wrap(wo_q, ONE_A);
			A_WO_H:   mem_addr = add_wrap(wo_q, HDR_A);
			A_WPTR:   mem_addr = wptr_q;
			A_HPOS:   mem_addr = hpos;
			A_HPOS1:  mem_addr = add_wrap(hpos, ONE_A);
			A_HPOS_H: mem_addr = add_wrap(hpos, HDR_A);
			A_RDP:    mem_addr = rdp_q;
			A_ONE:    mem_addr = ONE_A;
			default:  mem_addr = wo_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wsel)
			D_MARK_LO: mem_wdata = MARK_LEN;
			D_MARK_HI: mem_wdata = HDR_MARK;
			D_LEN_LO:  mem_wdata = len_q[BYTE_W-1:0];
			D_LEN_HI:  mem_wdata = BYTE_W'(len_q[LEN_W-1:BYTE_W]);
			D_BYTE:    mem_wdata = byte_q;
			default:   mem_wdata = byte_q;
		endcase
	end

	vlmrb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk(clk),
		.we(cmd.mem_we),
		.re(cmd.mem_re),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wo_q <= '0;
			ro_q <= '0;
			send_left_q <= '0;
			recv_left_q <= '0;
			dropping_q <= 1'b0;
			hwrap_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				hwrap_q <= 1'b0;
			end
			if (cmd.hdr_wrap) begin
				hwrap_q <= 1'b1;
				// a read commits the jump to the store start, a peek does not
				if (op_rd) begin
					ro_q <= '0;
				end
			end
			if (cmd.drop_step) begin
				send_left_q <= send_left_q - LEN_W'(1);
				if (send_left_q == LEN_W'(1)) begin
					dropping_q <= 1'b0;
				end
			end
			if (cmd.wr_step) begin
				send_left_q <= send_left_q - LEN_W'(1);
				if (send_left_q == LEN_W'(1)) begin
					wo_q <= add_wrap(wptr_q, ONE_A);
				end
			end
			if (cmd.reject && (len_q > LEN_W'(1))) begin
				dropping_q <= 1'b1;
				send_left_q <= len_q - LEN_W'(1);
			end
			if (cmd.wo_clear) begin
				wo_q <= '0;
			end
			if (cmd.wr_first) begin
				if (len_q == LEN_W'(1)) begin
					wo_q <= add_wrap(wo_q, HDR1_A);
				end else begin
					send_left_q <= len_q - LEN_W'(1);
				end
			end
			if (cmd.hdr_done && !op_pk) begin
				recv_left_q <= hlen;
			end
			if (cmd.rd_step) begin
				recv_left_q <= recv_left_q - LEN_W'(1);
				if (recv_left_q == LEN_W'(1)) begin
					ro_q <= add_wrap(rdp_q, ONE_A);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			byte_q <= in_byte;
			len_q <= in_len;
			res_byte_q <= '0;
			res_last_q <= 1'b0;
			res_st_q <= ST_OK;
			res_size_q <= '0;
		end
		if (cmd.set_st) begin
			res_st_q <= cmd.st;
		end
		if (cmd.wr_step) begin
			wptr_q <= add_wrap(wptr_q, ONE_A);
		end
		if (cmd.wr_first) begin
			wptr_q <= add_wrap(wo_q, HDR1_A);
		end
		if (cmd.hdr_hi) begin
			hi_q <= mem_rdata[HI_W-1:0];
		end
		if (cmd.hdr_done) begin
			if (op_pk) begin
				res_size_q <= hlen;
			end else begin
				rdp_q <= add_wrap(hpos, HDR_A);
			end
		end
		if (cmd.rd_step) begin
			res_byte_q <= mem_rdata;
			rdp_q <= add_wrap(rdp_q, ONE_A);
			if (recv_left_q == LEN_W'(1)) begin
				res_last_q <= 1'b1;
			end
		end
		if (cmd.out_load) begin
			out_byte_q <= res_byte_q;
			out_last_q <= res_last_q;
			out_st_q <= res_st_q;
			out_size_q <= res_size_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign out_status = out_st_q;
	assign out_size = out_size_q;

	`ASSERT_CLK(a_drop_has_bytes, clk, arst_n, !dropping_q || (send_left_q != '0))
	`ASSERT_CLK(a_read_not_empty, clk, arst_n, (recv_left_q == '0) || (ro_q != wo_q))
	`ASSERT_CLK(a_offsets_in_store, clk, arst_n, ((AW + 1)'(wo_q) < STORE_W) && ((AW + 1)'(ro_q) < STORE_W))

endmodule

`default_nettype wire

// ===== hw/rtl/variable_length_message_ring_buffer.sv =====
// one item at a time; a continued or dropped write byte and an unused op end in the evaluate
// state, a continued read byte after a data read, a first write byte after any wrap marker
// and, if stored, both header bytes and the data byte, a read or peek after header bytes 1
// and 0 (and any skipped marker) and a read's data byte; each header byte is its own access
// to the single-port store; a result waits in the output register while the next item is
// taken; reset clears offsets, counters and the output valid; the store needs no clearing
`default_nettype none

module variable_length_message_ring_buffer
	import vlmrb_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	vlmrb_in_if.sink    req,
	vlmrb_out_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	vlmrb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.sts(sts),
		.cmd(cmd)
	);

	vlmrb_dp #(
		.STORE_BYTES(STORE_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_op(req.op),
		.in_byte(req.data_byte),
		.in_len(req.msg_length),
		.out_ready(rsp.ready),
		.out_valid(rsp.valid),
		.out_byte(rsp.read_byte),
		.out_last(rsp.last),
		.out_status(rsp.status),
		.out_size(rsp.next_size),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

`default_nettype wire
